### hw/rtl/tsba_pkg.sv
package tsba_pkg;

  // Field widths of the request and result beats
  localparam int unsigned TexW     = 32;
  localparam int unsigned IdxCntW  = 16;
  localparam int unsigned SlotCntW = 6;
  localparam int unsigned SlotOutW = 5;
  localparam int unsigned CfgDataW = 16;

  typedef logic [TexW-1:0]     texture_t;
  typedef logic [IdxCntW-1:0]  idx_cnt_t;
  typedef logic [SlotCntW-1:0] slot_cnt_t;
  typedef logic [SlotOutW-1:0] slot_out_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // Request opcodes
  typedef enum logic {
    OP_QUAD  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_INDEX_LIMIT = 1'b0,
    CFG_SLOT_LIMIT  = 1'b1
  } cfg_reg_e;

  // Each quad adds two triangles
  localparam idx_cnt_t QuadIndices   = 16'd6;
  localparam idx_cnt_t IndexLimitCap = 16'd65532;
  localparam idx_cnt_t IndexLimitRst = 16'd60000;
  localparam slot_cnt_t SlotLimitRst = 6'd32;
  localparam slot_cnt_t SlotLimitMin = 6'd2;

endpackage

### hw/rtl/tsba_in_if.sv
interface tsba_in_if import tsba_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     op;
  texture_t texture_id;

  modport source (output valid, op, texture_id, input ready);
  modport sink   (input valid, op, texture_id, output ready);
endinterface

### hw/rtl/tsba_out_if.sv
interface tsba_out_if import tsba_pkg::*; ();
  logic      valid;
  logic      ready;
  slot_out_t slot_index;
  logic      batch_closed;
  idx_cnt_t  closed_index_count;
  slot_cnt_t closed_slot_count;

  modport source (output valid, slot_index, batch_closed, closed_index_count,
                  closed_slot_count, input ready);
  modport sink   (input valid, slot_index, batch_closed, closed_index_count,
                  closed_slot_count, output ready);
endinterface

### hw/rtl/texture_slot_batch_assigner_unit.sv
// Texture slot batch assigner.
// in_i carries one beat per quad request (op = quad, texture_id, 0 = color
// only) or an end-of-frame flush (op = flush). out_o returns exactly one
// beat per request: the slot given to the quad, and whether a non-empty
// batch was closed ahead of it, with that batch's index and slot counts.
// A flush closes a non-empty batch and returns slot 0.
// The request beat lands in an input register; a parallel compare against
// the slot table, the limit checks and the state update then run between
// that register and the result register. One request is taken every cycle
// as long as out_o is ready.
// When out_o stalls, the result holds, one more request may wait in the
// input register, then in_i.ready drops until the result is taken.
// Reset empties both registers, starts an empty batch (slot 1 is next,
// index count 0) and loads index_limit = 60000 and slot_limit = 32.
// cfg_we_i writes register cfg_idx_i (0 = index_limit, 1 = slot_limit)
// from cfg_data_i at the next rising edge; write only while idle.
module texture_slot_batch_assigner_unit import tsba_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  cfg_data_t   cfg_data_i,
  tsba_in_if.sink     in_i,
  tsba_out_if.source  out_o
);

  localparam int unsigned SlotIw = $clog2(MAX_SLOTS);
  localparam int unsigned SuW    = $clog2(MAX_SLOTS + 1);
  localparam logic [6:0]  MaxSlots7 = 7'(MAX_SLOTS);

  typedef logic [SuW-1:0]    su_t;
  typedef logic [SlotIw-1:0] slot_t;

  // Configuration registers
  idx_cnt_t  index_limit_q;
  slot_cnt_t slot_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_limit_q <= IndexLimitRst;
      slot_limit_q  <= SlotLimitRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_INDEX_LIMIT) begin
        index_limit_q <= cfg_data_i;
      end else begin
        slot_limit_q <= cfg_data_i[SlotCntW-1:0];
      end
    end
  end

  // Pipeline handshake
  logic     in_v_q;
  logic     in_op_q;
  texture_t in_tex_q;
  logic     out_v_q;
  logic     out_adv;
  logic     fire;

  assign out_adv    = !out_v_q || out_o.ready;
  assign fire       = in_v_q && out_adv;
  assign in_i.ready = !in_v_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q  <= in_i.op;
      in_tex_q <= in_i.texture_id;
    end
  end

  // Batch state
  texture_t slot_tex_q [MAX_SLOTS];
  su_t      su_q, su_d;
  idx_cnt_t bi_q, bi_d;

  // Effective limits
  idx_cnt_t   lim_idx;
  logic [6:0] lim_slot7;
  su_t        lim_slot;

  always_comb begin
    lim_idx   = (index_limit_q > IndexLimitCap) ? IndexLimitCap : index_limit_q;
    lim_slot7 = {1'b0, slot_limit_q};
    if (slot_limit_q < SlotLimitMin) begin
      lim_slot7 = {1'b0, SlotLimitMin};
    end else if (lim_slot7 > MaxSlots7) begin
      lim_slot7 = MaxSlots7;
    end
    lim_slot = SuW'(lim_slot7);
  end

  // Lookup, close decisions and next state
  logic      pre_close;
  logic      tex_hit;
  slot_t     hit_idx;
  su_t       su_a, su_b;
  idx_cnt_t  bi_a, bi_b;
  logic      do_alloc;
  logic      closed;
  idx_cnt_t  cnt_idx;
  su_t       cnt_su;
  slot_t     slot_res;
  slot_t     new_slot;

  always_comb begin
    pre_close = (in_op_q == OP_FLUSH) || (bi_q >= lim_idx);
    closed    = pre_close && (bi_q != '0);
    cnt_idx   = closed ? bi_q : '0;
    cnt_su    = closed ? su_q : '0;
    bi_a      = pre_close ? '0 : bi_q;
    su_a      = pre_close ? su_t'(1) : su_q;

    // Parallel compare over the bound slots of the current batch
    tex_hit = 1'b0;
    hit_idx = '0;
    for (int unsigned j = 1; j < MAX_SLOTS; j++) begin
      if ((su_t'(j) < su_a) && (slot_tex_q[j] == in_tex_q)) begin
        tex_hit = 1'b1;
        hit_idx = hit_idx | slot_t'(j);
      end
    end

    do_alloc = (in_op_q == OP_QUAD) && (in_tex_q != '0) && !tex_hit;
    bi_b     = bi_a;
    su_b     = su_a;
    // Slots full: close before binding the new texture
    if (do_alloc && (su_a >= lim_slot)) begin
      if (bi_a != '0) begin
        closed  = 1'b1;
        cnt_idx = bi_a;
        cnt_su  = su_a;
      end
      bi_b = '0;
      su_b = su_t'(1);
    end
    new_slot = su_b[SlotIw-1:0];

    slot_res = '0;
    if (in_op_q == OP_QUAD && in_tex_q != '0) begin
      slot_res = tex_hit ? hit_idx : new_slot;
    end

    if (in_op_q == OP_FLUSH) begin
      bi_d = '0;
      su_d = su_t'(1);
    end else begin
      bi_d = bi_b + QuadIndices;
      su_d = do_alloc ? su_b + su_t'(1) : su_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q <= '0;
      su_q <= su_t'(1);
    end else if (fire) begin
      bi_q <= bi_d;
      su_q <= su_d;
    end
  end

  // Slot table write on a new binding
  always_ff @(posedge clk_i) begin
    if (fire && do_alloc) begin
      slot_tex_q[new_slot] <= in_tex_q;
    end
  end

  // Result register
  slot_out_t out_slot_q;
  logic      out_closed_q;
  idx_cnt_t  out_cnt_idx_q;
  slot_cnt_t out_cnt_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_slot_q     <= SlotOutW'(slot_res);
      out_closed_q   <= closed;
      out_cnt_idx_q  <= cnt_idx;
      out_cnt_slot_q <= SlotCntW'(cnt_su);
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.slot_index         = out_slot_q;
  assign out_o.batch_closed       = out_closed_q;
  assign out_o.closed_index_count = out_cnt_idx_q;
  assign out_o.closed_slot_count  = out_cnt_slot_q;

endmodule
